>>> design/srr_pkg.sv
package srr_pkg;

    localparam int unsigned MaxFeaturesDef = 1024;
    localparam int unsigned KeyWidthDef    = 32;
    localparam int unsigned KeyPortWidth   = 32;
    localparam int unsigned IdWidth        = 10;
    localparam int unsigned CfgIdxWidth    = 1;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_SORT_ASCENDING = 1'b0,
        CFG_KEY_SIGNED     = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_LOAD_KEY = 1'b0,
        OP_RELABEL  = 1'b1
    } t_opcode;

    typedef struct packed {
        logic ascending;
        logic key_signed;
    } t_cmp_mode;

endpackage

>>> design/srr_cmp.sv
module srr_cmp #(
    parameter int unsigned KEY_WIDTH = srr_pkg::KeyWidthDef,
    parameter int unsigned CNT_WIDTH = 11
) (
    input  logic [KEY_WIDTH-1:0] i_key_a,
    input  logic [CNT_WIDTH-1:0] i_id_a,
    input  logic [KEY_WIDTH-1:0] i_key_b,
    input  logic [CNT_WIDTH-1:0] i_id_b,
    input  srr_pkg::t_cmp_mode   i_mode,
    output logic                 o_a_first
);
    import srr_pkg::*;

    logic [KEY_WIDTH-1:0] ka;
    logic [KEY_WIDTH-1:0] kb;
    logic                 sgn_flip;

    // signed order == unsigned order with the sign bit flipped
    assign sgn_flip = i_mode.key_signed;
    always_comb begin
        ka = i_key_a;
        kb = i_key_b;
        ka[KEY_WIDTH-1] = i_key_a[KEY_WIDTH-1] ^ sgn_flip;
        kb[KEY_WIDTH-1] = i_key_b[KEY_WIDTH-1] ^ sgn_flip;
        if (ka != kb) begin
            o_a_first = i_mode.ascending ? (ka < kb) : (ka > kb);
        end else begin
            o_a_first = i_id_a < i_id_b;
        end
    end

endmodule

>>> design/sort_rank_relabel_top.sv
// Rank-based feature relabeler. Key transactions (opcode 0) append one key per
// feature into an on-chip key memory, one per cycle while o_stall is low. The
// first relabel transaction (opcode 1) after any key load builds an old-id ->
// new-id map: feature 0 keeps id 0, features 1..n-1 get 1 + the number of other
// features in 1..n-1 that order ahead of them (ascending or descending key,
// signed or unsigned, ties by old id). One shared comparator walks every pair
// of features 1..n-1, reading key j in S_RDJ and comparing in S_CMP; o_stall
// stays high meanwhile. A relabel with a ready map goes through the map memory
// read in S_LOOK and S_RES to a registered result. Ids at or above the loaded
// count return id_error=1 and id 0. Keys past MAX_FEATURES are dropped. Only one
// transaction is in flight: the input stalls until the result is taken.
module sort_rank_relabel_top #(
    parameter int unsigned MAX_FEATURES = srr_pkg::MaxFeaturesDef,
    parameter int unsigned KEY_WIDTH    = srr_pkg::KeyWidthDef
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [srr_pkg::CfgIdxWidth-1:0]     i_cfg_index,
    input  logic                                i_cfg_data,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_opcode,
    input  logic [srr_pkg::KeyPortWidth-1:0]    i_key_value,
    input  logic [srr_pkg::IdWidth-1:0]         i_cell_feature_id,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [srr_pkg::IdWidth-1:0]         o_new_feature_id,
    output logic                                o_id_error
);
    import srr_pkg::*;

    localparam int unsigned AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int unsigned CW = $clog2(MAX_FEATURES + 1);
    localparam int unsigned XW = CW + IdWidth;

    typedef enum logic [2:0] {
        S_IDLE, S_RDI, S_GETI, S_RDJ, S_CMP, S_WR, S_LOOK, S_RES
    } t_state;

    t_state r_state;
    logic   r_asc, r_sgn;
    logic [CW-1:0] r_count, r_i, r_j, r_rank;
    logic   r_map_ready;
    logic [IdWidth-1:0] r_id;
    logic   r_out_valid, r_err;
    logic [IdWidth-1:0] r_out_id;
    logic [KEY_WIDTH-1:0] r_ki;

    // memories
    logic [KEY_WIDTH-1:0] key_mem [MAX_FEATURES];
    logic [AW-1:0]        map_mem [MAX_FEATURES];
    logic [KEY_WIDTH-1:0] r_kq;
    logic [AW-1:0]        r_mq;
    logic [AW-1:0]        key_raddr;

    logic in_acc, out_acc, key_wr, bad_id, j_first;
    t_cmp_mode mode;

    assign o_stall  = (r_state != S_IDLE) || r_out_valid;
    assign in_acc   = i_valid && !o_stall;
    assign out_acc  = r_out_valid && !i_stall;
    assign key_wr   = in_acc && (t_opcode'(i_opcode) == OP_LOAD_KEY)
                      && (r_count < CW'(MAX_FEATURES));
    assign bad_id   = XW'(r_id) >= XW'(r_count);
    assign key_raddr = (r_state == S_RDJ) ? r_j[AW-1:0] : r_i[AW-1:0];
    assign mode     = '{ascending: r_asc, key_signed: r_sgn};

    assign o_valid          = r_out_valid;
    assign o_new_feature_id = r_out_id;
    assign o_id_error       = r_err;

    // does feature j order ahead of feature i
    srr_cmp #(.KEY_WIDTH(KEY_WIDTH), .CNT_WIDTH(CW)) u_cmp (
        .i_key_a   (r_kq),
        .i_id_a    (r_j),
        .i_key_b   (r_ki),
        .i_id_b    (r_i),
        .i_mode    (mode),
        .o_a_first (j_first)
    );

    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            key_mem[r_count[AW-1:0]] <= KEY_WIDTH'(i_key_value);
        end
        r_kq <= key_mem[key_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            map_mem[r_i[AW-1:0]] <= r_rank[AW-1:0];
        end
        r_mq <= map_mem[AW'(r_id)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_asc       <= 1'b0;
            r_sgn       <= 1'b1;
            r_count     <= '0;
            r_map_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_SORT_ASCENDING: r_asc <= i_cfg_data;
                    CFG_KEY_SIGNED:     r_sgn <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (t_opcode'(i_opcode) == OP_LOAD_KEY) begin
                            r_map_ready <= 1'b0;
                            if (key_wr) begin
                                r_count <= r_count + 1'b1;
                            end
                        end else begin
                            r_id <= i_cell_feature_id;
                            r_i  <= '0;
                            if (!r_map_ready && (r_count != '0)) begin
                                r_state <= S_RDI;
                            end else begin
                                r_map_ready <= 1'b1;
                                r_state     <= S_LOOK;
                            end
                        end
                    end
                end
                S_RDI: begin
                    r_rank <= '0;
                    // feature 0 stays at rank 0
                    r_state <= (r_i == '0) ? S_WR : S_GETI;
                end
                S_GETI: begin
                    r_ki    <= r_kq;
                    r_j     <= CW'(1);
                    r_rank  <= CW'(1);
                    r_state <= S_RDJ;
                end
                S_RDJ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if ((r_j != r_i) && j_first) begin
                        r_rank <= r_rank + 1'b1;
                    end
                    r_j     <= r_j + 1'b1;
                    r_state <= (r_j + 1'b1 == r_count) ? S_WR : S_RDJ;
                end
                S_WR: begin
                    r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 == r_count) begin
                        r_map_ready <= 1'b1;
                        r_state     <= S_LOOK;
                    end else begin
                        r_state <= S_RDI;
                    end
                end
                S_LOOK: begin
                    r_state <= S_RES;
                end
                S_RES: begin
                    r_err       <= bad_id;
                    r_out_id    <= bad_id ? '0 : IdWidth'(r_mq);
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import srr_pkg::*;

    localparam int unsigned MaxFeat    = MaxFeaturesDef;
    localparam int unsigned WatchLimit = 12000000;
    localparam int unsigned NumRandom  = 500;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0]  i_cfg_index = '0;
    logic                    i_cfg_data = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_opcode = 1'b0;
    logic [KeyPortWidth-1:0] i_key_value = '0;
    logic [IdWidth-1:0]      i_cell_feature_id = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b1;
    logic [IdWidth-1:0]      o_new_feature_id;
    logic                    o_id_error;

    always #5 i_clk = ~i_clk;

    sort_rank_relabel_top u_top (.*);

    // Expected relabel results, oldest first.
    typedef struct packed {
        logic [IdWidth-1:0] new_id;
        logic               id_err;
    } t_relabel_res;
    t_relabel_res relabel_q[$];

    // Shadow of the block's state.
    logic [KeyPortWidth-1:0] key_mem [MaxFeat];
    logic [IdWidth-1:0]      id_map  [MaxFeat];
    int unsigned             n_keys;
    bit                      map_built;
    bit                      mode_asc;
    bit                      mode_signed;

    int unsigned errors;
    int unsigned n_results;
    int unsigned n_sorts;
    int unsigned idle_cycles;

    task automatic report(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Order key of feature a ahead of feature b; ties by old id.
    function automatic bit ranks_ahead(input int unsigned a, input int unsigned b);
        logic [KeyPortWidth-1:0] ka;
        logic [KeyPortWidth-1:0] kb;
        ka = key_mem[a];
        kb = key_mem[b];
        if (mode_signed) begin
            ka[KeyPortWidth-1] = ~ka[KeyPortWidth-1];
            kb[KeyPortWidth-1] = ~kb[KeyPortWidth-1];
        end
        if (ka != kb) return mode_asc ? (ka < kb) : (ka > kb);
        return a < b;
    endfunction

    // Rank-count map: feature 0 fixed, others placed by how many outrank them.
    task automatic rebuild_id_map();
        int unsigned ahead;
        id_map[0] = '0;
        for (int unsigned i = 1; i < n_keys; i++) begin
            ahead = 1;
            for (int unsigned j = 1; j < n_keys; j++)
                if (j != i && ranks_ahead(j, i)) ahead++;
            id_map[i] = IdWidth'(ahead);
        end
        map_built = 1'b1;
        n_sorts++;
    endtask

    // Predict one accepted input transaction.
    task automatic predict_item(input logic op, input logic [KeyPortWidth-1:0] key,
                                input logic [IdWidth-1:0] cell_id);
        t_relabel_res r;
        if (t_opcode'(op) == OP_LOAD_KEY) begin
            if (n_keys < MaxFeat) begin
                key_mem[n_keys] = key;
                n_keys++;
            end
            map_built = 1'b0;
        end else begin
            if (!map_built) rebuild_id_map();
            if (cell_id >= n_keys) begin
                r.new_id = '0;
                r.id_err = 1'b1;
            end else begin
                r.new_id = id_map[cell_id];
                r.id_err = 1'b0;
            end
            relabel_q = {relabel_q, r};
        end
    endtask

    // Random gap: mostly none or short, occasionally long.
    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Drive one transaction and hold it until accepted; valid stays up
    // until the next transaction, a gap or a drain takes it down.
    task automatic send_item(input logic op, input logic [KeyPortWidth-1:0] key,
                             input logic [IdWidth-1:0] cell_id, input bit gaps);
        int unsigned g;
        g = gaps ? pick_gap() : 0;
        if (g != 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid           <= 1'b1;
        i_opcode          <= op;
        i_key_value       <= key;
        i_cell_feature_id <= cell_id;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        predict_item(op, key, cell_id);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input bit val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_SORT_ASCENDING) mode_asc = val;
        else mode_signed = val;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (relabel_q.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    // Output side: random stalls, with stretches of none.
    bit stall_free;
    always @(negedge i_clk) begin
        if ($urandom_range(63) == 0) stall_free <= ~stall_free;
        if (!i_rst_n) i_stall <= 1'b1;
        else if (stall_free) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 30) ? 1'b1
                      : ($urandom_range(99) < 3);
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_relabel_res exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (relabel_q.size() == 0) begin
                report("result with no pending expectation");
            end else begin
                exp_r = relabel_q.pop_front();
                if (o_new_feature_id !== exp_r.new_id)
                    report($sformatf("new_feature_id got %0d exp %0d",
                                     o_new_feature_id, exp_r.new_id));
                if (o_id_error !== exp_r.id_err)
                    report($sformatf("id_error got %0b exp %0b",
                                     o_id_error, exp_r.id_err));
            end
        end
    end

    // Watchdog: counts cycles with no transaction accepted on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("watchdog expired");
            $display("FAIL sort_rank_relabel_top");
            $finish;
        end
    end

    // Directed rows: op, key, cell id, check-by-value, expected id, expected error.
    typedef struct {
        bit                      op;
        logic [KeyPortWidth-1:0] key;
        logic [IdWidth-1:0]      cell_id;
        bit                      fixed;
        logic [IdWidth-1:0]      exp_id;
        bit                      exp_err;
    } t_row;

    t_row rows[] = '{
        // empty store: every id is out of range
        '{1, 32'h0,        10'd0,    1, 10'd0, 1},
        '{1, 32'h0,        10'd1023, 1, 10'd0, 1},
        // keys at the extremes
        '{0, 32'h8000_0000, 10'd0,   0, 10'd0, 0},
        '{0, 32'h7FFF_FFFF, 10'd0,   0, 10'd0, 0},
        '{0, 32'hFFFF_FFFF, 10'd0,   0, 10'd0, 0},
        '{0, 32'h0000_0000, 10'd0,   0, 10'd0, 0},
        '{0, 32'h7FFF_FFFF, 10'd0,   0, 10'd0, 0},
        '{1, 32'h0,        10'd0,    1, 10'd0, 0},
        '{1, 32'h0,        10'd1,    0, 10'd0, 0},
        '{1, 32'h0,        10'd2,    0, 10'd0, 0},
        '{1, 32'h0,        10'd3,    0, 10'd0, 0},
        '{1, 32'h0,        10'd4,    0, 10'd0, 0},
        '{1, 32'h0,        10'd5,    1, 10'd0, 1},
        '{1, 32'h0,        10'd1023, 1, 10'd0, 1},
        // key after relabel forces a re-sort
        '{0, 32'h1234_5678, 10'd0,   0, 10'd0, 0},
        '{1, 32'h0,        10'd5,    0, 10'd0, 0},
        '{1, 32'h0,        10'd2,    0, 10'd0, 0}
    };

    int unsigned n_rand;
    int unsigned set_size;

    initial begin
        n_keys = 0;
        map_built = 0;
        mode_asc = 0;
        mode_signed = 1;
        errors = 0;
        n_results = 0;
        n_sorts = 0;
        idle_cycles = 0;
        stall_free = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            send_item(rows[i].op, rows[i].key, rows[i].cell_id, 1'b0);
            if (rows[i].op && rows[i].fixed) begin
                relabel_q[$].new_id = rows[i].exp_id;
                relabel_q[$].id_err = rows[i].exp_err;
            end
        end
        drain();

        // Register change after sort: map keeps its old order until a key comes.
        cfg_write(CFG_SORT_ASCENDING, 1'b1);
        cfg_write(CFG_KEY_SIGNED, 1'b0);
        send_item(OP_RELABEL, '0, 10'd1, 1'b1);
        send_item(OP_RELABEL, '0, 10'd3, 1'b1);
        send_item(OP_LOAD_KEY, 32'hFFFF_FFFF, '0, 1'b1);
        for (int unsigned c = 0; c < 8; c++) send_item(OP_RELABEL, '0, IdWidth'(c), 1'b1);
        drain();

        // Random phases: new keys appended per phase, small sets with many ties.
        n_rand = 0;
        while (n_rand < NumRandom) begin
            cfg_write(CFG_SORT_ASCENDING, 1'($urandom_range(1)));
            cfg_write(CFG_KEY_SIGNED, 1'($urandom_range(1)));
            @(negedge i_clk);
            i_rst_n <= 1'b1;
            set_size = ($urandom_range(9) == 0) ? $urandom_range(40, 16)
                                                : $urandom_range(8, 1);
            repeat (set_size) begin
                logic [KeyPortWidth-1:0] k;
                case ($urandom_range(3))
                    0: k = $urandom_range(3);
                    1: k = 32'hFFFF_FFFC | $urandom_range(3);
                    2: k = 32'h7FFF_FFFE + $urandom_range(3);
                    default: k = $urandom();
                endcase
                send_item(OP_LOAD_KEY, k, '0, 1'b1);
                n_rand++;
            end
            repeat ($urandom_range(12, 4)) begin
                logic [IdWidth-1:0] c;
                c = ($urandom_range(9) == 0) ? IdWidth'($urandom())
                                             : IdWidth'($urandom_range(n_keys));
                if ($urandom_range(15) == 0)
                    send_item(OP_LOAD_KEY, $urandom(), '0, 1'b1);
                else
                    send_item(OP_RELABEL, '0, c, 1'b1);
                n_rand++;
            end
            drain();
        end

        // Fill the store to the limit, then one key more is dropped.
        while (n_keys < MaxFeat)
            send_item(OP_LOAD_KEY, $urandom(), '0, 1'b0);
        send_item(OP_LOAD_KEY, 32'h0, '0, 1'b0);
        send_item(OP_RELABEL, '0, 10'd1023, 1'b0);
        send_item(OP_RELABEL, '0, 10'd0, 1'b1);
        send_item(OP_RELABEL, '0, IdWidth'($urandom()), 1'b1);

        drain();
        $display("covered %0d results over %0d map builds, last store %0d keys",
                 n_results, n_sorts, n_keys);
        $display("both sort directions and key modes, bad ids, full store");
        if (errors == 0 && relabel_q.size() == 0) begin
            $display("PASS sort_rank_relabel_top");
        end else begin
            $display("FAIL sort_rank_relabel_top");
        end
        $finish;
    end
endmodule
